@@ sv/cc20_pkg.sv @@
package cc20_pkg;

	localparam logic [31:0] SIGMA0 = 32'h6170_7865;
	localparam logic [31:0] SIGMA1 = 32'h3320_646e;
	localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
	localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

	localparam int          CFG_IDX_W   = 3;
	localparam int          CFG_DATA_W  = 64;
	localparam int          STEP_W      = 6;
	localparam logic [STEP_W-1:0] LAST_STEP = 6'd39;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_PART_0    = 3'd0,
		REG_KEY_PART_1    = 3'd1,
		REG_KEY_PART_2    = 3'd2,
		REG_KEY_PART_3    = 3'd3,
		REG_NONCE_LOW     = 3'd4,
		REG_NONCE_HIGH    = 3'd5,
		REG_INIT_COUNTER  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic round;
		logic half;
		logic diag;
		logic finish;
	} cc20_cmd_t;

	typedef struct packed {
		logic need_block;
		logic out_free;
	} cc20_status_t;

	// one half of a quarter round: rotations 16/12 first, 8/7 second
	function automatic logic [127:0] qhalf(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d, input logic second);
		logic [31:0] a2;
		logic [31:0] b2;
		logic [31:0] c2;
		logic [31:0] d2;
		logic [31:0] dx;
		logic [31:0] bx;
		a2 = a + b;
		dx = d ^ a2;
		d2 = second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
		c2 = c + d2;
		bx = b ^ c2;
		b2 = second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
		return {a2, b2, c2, d2};
	endfunction

endpackage

@@ sv/cc20_if.sv @@
interface cc20_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cc20_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

@@ sv/cc20_ctrl.sv @@
module cc20_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  cc20_pkg::cc20_status_t status,
	output cc20_pkg::cc20_cmd_t    cmd
);
	import cc20_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_ROUND  = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              accept;

	assign in_ready = (state_q == ST_IDLE) && status.out_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd        = '0;
		cmd.accept = accept;
		cmd.load   = accept && status.need_block;
		cmd.round  = (state_q == ST_ROUND);
		cmd.half   = step_q[0];
		cmd.diag   = step_q[1];
		cmd.finish = (state_q == ST_FINISH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (accept && status.need_block) state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ sv/cc20_datapath.sv @@
module cc20_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cc20_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cc20_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic [7:0]                          data_byte,
	input  logic                                last_byte,
	input  cc20_pkg::cc20_cmd_t                 cmd,
	output cc20_pkg::cc20_status_t              status,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          out_byte,
	output logic                                out_last
);
	import cc20_pkg::*;

	logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce_lo_q;
	logic [31:0] nonce_hi_q, init_ctr_q;

	logic [31:0] w_q [16];
	logic [31:0] ks_q [16];
	logic [31:0] init_w [16];
	logic [31:0] w_next [16];

	logic [5:0]  pos_q;
	logic [31:0] ctr_q;
	logic        in_msg_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic [7:0]  data_q;
	logic        last_q;

	logic [5:0]  eff_pos;
	logic [31:0] eff_ctr;
	logic [31:0] ks_word;
	logic [7:0]  ks_byte;
	logic [31:0] sum0;

	assign eff_pos = in_msg_q ? pos_q : 6'd0;
	assign eff_ctr = in_msg_q ? ctr_q : init_ctr_q;

	assign status.need_block = (eff_pos == 6'd0);
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	always_comb begin
		init_w[0]  = SIGMA0;
		init_w[1]  = SIGMA1;
		init_w[2]  = SIGMA2;
		init_w[3]  = SIGMA3;
		init_w[4]  = key0_q[31:0];
		init_w[5]  = key0_q[63:32];
		init_w[6]  = key1_q[31:0];
		init_w[7]  = key1_q[63:32];
		init_w[8]  = key2_q[31:0];
		init_w[9]  = key2_q[63:32];
		init_w[10] = key3_q[31:0];
		init_w[11] = key3_q[63:32];
		init_w[12] = cmd.load ? eff_ctr : ctr_q;
		init_w[13] = nonce_lo_q[31:0];
		init_w[14] = nonce_lo_q[63:32];
		init_w[15] = nonce_hi_q;
	end

	// four quarter rounds side by side, column or diagonal lane mapping
	always_comb begin
		logic [1:0]   ob, oc, od;
		logic [3:0]   ib, ic, id;
		logic [127:0] r;
		w_next = w_q;
		for (int l = 0; l < 4; l++) begin
			ob = 2'(l) + {1'b0, cmd.diag};
			oc = 2'(l) + {cmd.diag, 1'b0};
			od = 2'(l) + {cmd.diag, cmd.diag};
			ib = {2'b01, ob};
			ic = {2'b10, oc};
			id = {2'b11, od};
			r  = qhalf(w_q[l], w_q[ib], w_q[ic], w_q[id], cmd.half);
			w_next[l]  = r[127:96];
			w_next[ib] = r[95:64];
			w_next[ic] = r[63:32];
			w_next[id] = r[31:0];
		end
	end

	assign ks_word = ks_q[eff_pos[5:2]];
	assign ks_byte = 8'(ks_word >> {eff_pos[1:0], 3'b000});
	assign sum0    = w_q[0] + init_w[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q     <= '0;
			key1_q     <= '0;
			key2_q     <= '0;
			key3_q     <= '0;
			nonce_lo_q <= '0;
			nonce_hi_q <= '0;
			init_ctr_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_PART_0:   key0_q     <= cfg_wdata;
				REG_KEY_PART_1:   key1_q     <= cfg_wdata;
				REG_KEY_PART_2:   key2_q     <= cfg_wdata;
				REG_KEY_PART_3:   key3_q     <= cfg_wdata;
				REG_NONCE_LOW:    nonce_lo_q <= cfg_wdata;
				REG_NONCE_HIGH:   nonce_hi_q <= cfg_wdata[31:0];
				REG_INIT_COUNTER: init_ctr_q <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			ctr_q       <= '0;
			in_msg_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.finish || (cmd.accept && !status.need_block) ||
				(out_valid_q && !out_ready);
			if (cmd.accept) begin
				pos_q    <= eff_pos + 6'd1;
				ctr_q    <= eff_ctr + {31'd0, (eff_pos == 6'd63)};
				in_msg_q <= !last_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			data_q <= data_byte;
			last_q <= last_byte;
			if (!status.need_block) begin
				out_byte_q <= data_byte ^ ks_byte;
				out_last_q <= last_byte;
			end
		end
		if (cmd.load) w_q <= init_w;
		else if (cmd.round) w_q <= w_next;
		if (cmd.finish) begin
			for (int i = 0; i < 16; i++) ks_q[i] <= w_q[i] + init_w[i];
			out_byte_q <= data_q ^ sum0[7:0];
			out_last_q <= last_q;
		end
	end

endmodule

@@ sv/chacha20_stream_cipher_unit.sv @@
// ChaCha20 (20 rounds) byte stream cipher: each request byte is XORed with the
// next keystream byte, so the unit both encrypts and decrypts. Program the key,
// nonce and initial block counter through the write port while no request is
// in flight. A byte inside a keystream block is accepted and answered in the
// next cycle, one per cycle while the output is not stalled. The first byte
// of each block (and of each message) waits for a new block: one shared set
// of four quarter-round lanes takes 40 half-round steps, then the feed-forward
// add is done, and no new request is taken until that byte's result appears.
module chacha20_stream_cipher_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	cc20_in_if.sink                         in_ch,
	cc20_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cc20_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import cc20_pkg::*;

	cc20_cmd_t    cmd;
	cc20_status_t status;
	logic         in_ready;
	logic         out_valid;
	logic [7:0]   out_byte;
	logic         out_last;

	assign in_ch.ready     = in_ready;
	assign out_ch.valid    = out_valid;
	assign out_ch.out_byte = out_byte;
	assign out_ch.out_last = out_last;

	cc20_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	cc20_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.data_byte (in_ch.data_byte),
		.last_byte (in_ch.last_byte),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

@@ test/cc20_checker.sv @@
module cc20_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	cc20_in_if                              in_ch,
	cc20_out_if                             out_ch,
	input  logic                            cfg_we,
	input  logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cc20_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                              pending,
	output int                              fails
);
	import cc20_pkg::*;

	typedef logic [15:0][31:0] kblock_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} cipher_byte_t;

	localparam logic [3:0][31:0] EXPAND_CONST =
		{32'h6b20_6574, 32'h7962_2d32, 32'h3320_646e, 32'h6170_7865};

	logic [63:0]  key_w [4];
	logic [63:0]  nonce_lo;
	logic [31:0]  nonce_hi;
	logic [31:0]  ctr_start;

	kblock_t      keystream;
	logic [5:0]   pos;
	logic [31:0]  ctr;
	logic         in_msg;

	cipher_byte_t expected_q [$];
	cipher_byte_t want;
	cipher_byte_t got;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic kblock_t quarter(input kblock_t s, input int a, input int b,
		input int c, input int d);
		s[a] = s[a] + s[b];
		s[d] = rotl32(s[d] ^ s[a], 16);
		s[c] = s[c] + s[d];
		s[b] = rotl32(s[b] ^ s[c], 12);
		s[a] = s[a] + s[b];
		s[d] = rotl32(s[d] ^ s[a], 8);
		s[c] = s[c] + s[d];
		s[b] = rotl32(s[b] ^ s[c], 7);
		return s;
	endfunction

	function automatic kblock_t keystream_block(input logic [31:0] counter);
		kblock_t init_w;
		kblock_t w;
		init_w[3:0] = EXPAND_CONST;
		for (int k = 0; k < 4; k++) begin
			init_w[4 + 2 * k] = key_w[k][31:0];
			init_w[5 + 2 * k] = key_w[k][63:32];
		end
		init_w[12] = counter;
		init_w[13] = nonce_lo[31:0];
		init_w[14] = nonce_lo[63:32];
		init_w[15] = nonce_hi;
		w = init_w;
		for (int r = 0; r < 10; r++) begin
			w = quarter(w, 0, 4, 8, 12);
			w = quarter(w, 1, 5, 9, 13);
			w = quarter(w, 2, 6, 10, 14);
			w = quarter(w, 3, 7, 11, 15);
			w = quarter(w, 0, 5, 10, 15);
			w = quarter(w, 1, 6, 11, 12);
			w = quarter(w, 2, 7, 8, 13);
			w = quarter(w, 3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++)
			w[i] = w[i] + init_w[i];
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++)
				key_w[k] = '0;
			nonce_lo = '0;
			nonce_hi = '0;
			ctr_start = '0;
			keystream = '0;
			pos = '0;
			ctr = '0;
			in_msg = 1'b0;
			expected_q.delete();
			pending = 0;
			fails = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_PART_0:   key_w[0] = cfg_wdata;
					REG_KEY_PART_1:   key_w[1] = cfg_wdata;
					REG_KEY_PART_2:   key_w[2] = cfg_wdata;
					REG_KEY_PART_3:   key_w[3] = cfg_wdata;
					REG_NONCE_LOW:    nonce_lo = cfg_wdata;
					REG_NONCE_HIGH:   nonce_hi = cfg_wdata[31:0];
					REG_INIT_COUNTER: ctr_start = cfg_wdata[31:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				if (!in_msg) begin
					ctr = ctr_start;
					pos = '0;
					in_msg = 1'b1;
				end
				if (pos == 6'd0)
					keystream = keystream_block(ctr);
				want.data = in_ch.data_byte ^ keystream[pos[5:2]][{pos[1:0], 3'b000} +: 8];
				want.last = in_ch.last_byte;
				expected_q.push_back(want);
				pos = pos + 6'd1;
				if (pos == 6'd0)
					ctr = ctr + 32'd1;
				if (in_ch.last_byte)
					in_msg = 1'b0;
			end
			if (out_ch.valid && out_ch.ready) begin
				got.data = out_ch.out_byte;
				got.last = out_ch.out_last;
				if (expected_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result: byte %02h last %0b", got.data, got.last);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						fails++;
						if (fails <= 10)
							$display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
								want.data, want.last, got.data, got.last);
					end
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

@@ test/tb.sv @@
module tb;
	import cc20_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	bit gap_on;
	bit stall_on;
	int stall_left = 0;
	int sent = 0;
	int pending;
	int fails;

	cc20_in_if  in_ch ();
	cc20_out_if out_ch ();

	chacha20_stream_cipher_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	cc20_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pending   (pending),
		.fails     (fails)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("chacha20_stream_cipher_unit verification failed");
		$finish;
	end

	// output backpressure in bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else if (stall_on && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 18);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic lst);
		if (gap_on && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.last_byte <= lst;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent++;
	endtask

	task automatic send_message(input int len, input bit close);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)), close && (i == len - 1));
	endtask

	// stop sending and wait until every request is answered
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [63:0] k0, input logic [63:0] k1,
		input logic [63:0] k2, input logic [63:0] k3, input logic [63:0] nl,
		input logic [31:0] nh, input logic [31:0] ctr0);
		put_reg(REG_KEY_PART_0, k0);
		put_reg(REG_KEY_PART_1, k1);
		put_reg(REG_NONE, {$urandom, $urandom});
		put_reg(REG_KEY_PART_2, k2);
		put_reg(REG_KEY_PART_3, k3);
		put_reg(REG_NONCE_LOW, nl);
		put_reg(REG_NONCE_HIGH, {32'd0, nh});
		put_reg(REG_INIT_COUNTER, {32'd0, ctr0});
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] pick64();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [31:0] pick32();
		case ($urandom_range(0, 6))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'hffff_fffe;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int n_msg;
		int len;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data_byte <= '0;
		in_ch.last_byte <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		gap_on = 1'b0;
		stall_on = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: all-zero key, nonce and counter
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'ha5, 1'b1);
		send_byte(8'h5a, 1'b1);
		drain();

		load_settings(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
			64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918,
			64'h4a00_0000_0900_0000, 32'h0000_0000, 32'h0000_0001);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h7f, 1'b0);
		send_byte(8'hfe, 1'b0);
		drain();
		// key change inside a message, seen only from the next block on
		put_reg(REG_KEY_PART_0, '1);
		cfg_we <= 1'b0;
		send_byte(8'h55, 1'b0);
		send_byte(8'haa, 1'b0);
		send_byte(8'h0f, 1'b0);
		send_byte(8'hf0, 1'b1);
		send_byte(8'h3c, 1'b1);
		drain();

		// extremes with counter wrap across block boundaries
		gap_on = 1'b1;
		stall_on = 1'b1;
		load_settings('1, '1, '1, '1, '1, 32'hffff_ffff, 32'hffff_ffff);
		send_message(130, 1'b1);
		drain();
		load_settings('0, '0, '0, '0, '0, 32'h0000_0000, 32'hffff_fffe);
		send_message(140, 1'b1);
		drain();

		while (sent < 1200) begin
			if (sent >= 1000) begin
				gap_on = 1'b0;
				stall_on = 1'b0;
			end else begin
				gap_on = $urandom_range(0, 3) != 0;
				stall_on = $urandom_range(0, 3) != 0;
			end
			if ($urandom_range(0, 3) != 0)
				load_settings(pick64(), pick64(), pick64(), pick64(), pick64(), pick32(), pick32());
			n_msg = $urandom_range(1, 4);
			for (int m = 0; m < n_msg; m++) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(65, 200) : $urandom_range(1, 64);
				// sometimes leave the message open across the next settings change
				send_message(len, !(m == n_msg - 1 && $urandom_range(0, 2) == 0));
			end
			drain();
		end

		repeat (60) @(posedge clk);
		if (fails == 0)
			$display("chacha20_stream_cipher_unit verification clean");
		else
			$display("chacha20_stream_cipher_unit verification failed");
		$finish;
	end

endmodule
